/* rtl/core/bnfa_pkg.sv */
package bnfa_pkg;

  localparam int ADDR_W            = 48;
  localparam int CNT_W             = 11;
  localparam int CB_W              = 21;
  localparam int STATUS_W          = 2;
  localparam int CFG_IDX_W         = 2;
  localparam int DEFAULT_MAX_CELLS = 1024;

  localparam logic [CB_W-1:0]  CELL_BYTES_RESET   = 21'd4096;
  localparam logic [CNT_W-1:0] CELLS_IN_USE_RESET = 11'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOC_FAIL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREE_CLIPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 2'd2;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] free_address;
    logic [CNT_W-1:0]  cell_count;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_address;
  } alloc_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FREE_SETUP,
    S_FREE_GO,
    S_CHK_RD,
    S_CHK_EV,
    S_MRK_START,
    S_MRK_RD,
    S_MRK_EV,
    S_MUL,
    S_ADDR,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DIV,
    OP_FREE_SETUP,
    OP_ROW_START,
    OP_CHECK,
    OP_MARK,
    OP_FAIL,
    OP_MUL,
    OP_ADDR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic reject;
    logic zero_count;
    logic div_last;
    logic free_empty;
    logic row_ok;
    logic row_last;
    logic out_full;
  } dp_status_t;

endpackage

/* rtl/core/bnfa_ram.sv */
module bnfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bnfa_ctrl.sv */
module bnfa_ctrl import bnfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        priority if (st.is_free) state_next = S_DIV;
        else if (st.reject)      state_next = S_DONE;
        else if (st.zero_count)  state_next = S_MUL;
        else                     state_next = S_CHK_RD;
      end
      S_DIV: begin
        if (st.div_last) state_next = S_FREE_SETUP;
      end
      S_FREE_SETUP: state_next = S_FREE_GO;
      S_FREE_GO: begin
        state_next = st.free_empty ? S_DONE : S_MRK_RD;
      end
      S_CHK_RD: state_next = S_CHK_EV;
      S_CHK_EV: begin
        priority if (!st.row_ok) state_next = S_DONE;
        else if (st.row_last)    state_next = S_MRK_START;
        else                     state_next = S_CHK_RD;
      end
      S_MRK_START: state_next = S_MRK_RD;
      S_MRK_RD: state_next = S_MRK_EV;
      S_MRK_EV: begin
        priority if (!st.row_last) state_next = S_MRK_RD;
        else if (st.is_free)       state_next = S_DONE;
        else                       state_next = S_MUL;
      end
      S_MUL:  state_next = S_ADDR;
      S_ADDR: state_next = S_DONE;
      S_DONE: begin
        if (!st.out_full || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: cmd.op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_SETUP: begin
        priority if (st.is_free) cmd.op = OP_NONE;
        else if (st.reject)      cmd.op = OP_FAIL;
        else if (st.zero_count)  cmd.op = OP_NONE;
        else                     cmd.op = OP_ROW_START;
      end
      S_DIV:        cmd.op = OP_DIV;
      S_FREE_SETUP: cmd.op = OP_FREE_SETUP;
      S_FREE_GO: begin
        if (!st.free_empty) cmd.op = OP_ROW_START;
      end
      S_CHK_RD:    cmd.op = OP_NONE;
      S_CHK_EV:    cmd.op = OP_CHECK;
      S_MRK_START: cmd.op = OP_ROW_START;
      S_MRK_RD:    cmd.op = OP_NONE;
      S_MRK_EV:    cmd.op = OP_MARK;
      S_MUL:       cmd.op = OP_MUL;
      S_ADDR:      cmd.op = OP_ADDR;
      S_DONE: begin
        cmd.out_load = !st.out_full || out_ready;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/core/bnfa_dp.sv */
module bnfa_dp import bnfa_pkg::*; #(
  parameter int MAX_CELLS = DEFAULT_MAX_CELLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  alloc_req_t           in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alloc_rsp_t           out_data,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           st
);

  localparam int WORD_BITS = (MAX_CELLS >= 32) ? 32 : 8;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int ROWS      = (MAX_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int POS_W     = $clog2(MAX_CELLS);
  localparam int RUN_W     = POS_W + 1;
  localparam int CELL_W    = ROW_W + WB_W;
  localparam int CMP_W     = (CELL_W > RUN_W) ? CELL_W : RUN_W;
  localparam int NUM_W     = (RUN_W > CNT_W) ? RUN_W : CNT_W;
  localparam int SUM_W     = NUM_W + 1;
  localparam int WIDE_W    = ADDR_W + 1;
  localparam int DCNT_W    = $clog2(ADDR_W);
  localparam int PROD_W    = RUN_W + CB_W;

  // configuration registers
  logic [ADDR_W-1:0] region_base;
  logic [CB_W-1:0]   cell_bytes;
  logic [CNT_W-1:0]  cells_in_use;

  // control state
  logic [POS_W-1:0]  next_pos;
  logic [ROW_W-1:0]  clr_row;

  // item payload
  logic              is_free;
  logic              reject;
  logic              zero_count;
  logic              free_empty;
  logic [CNT_W-1:0]  cnt;
  logic [RUN_W-1:0]  lo;
  logic [RUN_W-1:0]  hi;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  row_last_q;
  logic [ADDR_W-1:0] dd;
  logic [CB_W-1:0]   rem;
  logic [DCNT_W-1:0] div_cnt;
  logic [PROD_W-1:0] prod;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;

  logic [CB_W-1:0]   cb_eff;
  logic [NUM_W-1:0]  cu;
  logic [NUM_W-1:0]  n_eff;
  logic [SUM_W-1:0]  np_sum;
  logic [POS_W-1:0]  start_sel;
  logic [CB_W:0]     rem_sh;
  logic              div_ge;
  logic [WIDE_W-1:0] pos_end;
  logic [WIDE_W-1:0] n_wide;
  logic              clipped;
  logic [RUN_W-1:0]  last_pos;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rdata;
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [CELL_W-1:0]    cell_idx [WORD_BITS];

  assign cfg_ready = 1'b1;

  assign cb_eff = (cell_bytes == '0) ? CB_W'(1) : cell_bytes;
  assign cu     = NUM_W'(cells_in_use);

  always_comb begin
    priority if (cu == '0)            n_eff = NUM_W'(1);
    else if (cu > NUM_W'(MAX_CELLS))  n_eff = NUM_W'(MAX_CELLS);
    else                              n_eff = cu;
  end

  // next-fit start: wrap to cell 0 when the run would pass the region end
  assign np_sum    = SUM_W'(next_pos) + SUM_W'(in_data.cell_count);
  assign start_sel = (np_sum > SUM_W'(n_eff)) ? '0 : next_pos;

  // restoring divider, one quotient bit per step
  assign rem_sh = {rem, dd[ADDR_W-1]};
  assign div_ge = rem_sh >= {1'b0, cb_eff};

  assign pos_end = {1'b0, dd} + WIDE_W'(cnt);
  assign n_wide  = WIDE_W'(n_eff);
  assign clipped = pos_end > n_wide;

  assign last_pos = hi - RUN_W'(1);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      cell_idx[b] = {row_q, WB_W'(b)};
      mask[b] = (CMP_W'(cell_idx[b]) >= CMP_W'(lo)) && (CMP_W'(cell_idx[b]) < CMP_W'(hi));
    end
  end

  assign st.clear_last = clr_row == ROW_W'(ROWS - 1);
  assign st.is_free    = is_free;
  assign st.reject     = reject;
  assign st.zero_count = zero_count;
  assign st.div_last   = div_cnt == DCNT_W'(ADDR_W - 1);
  assign st.free_empty = free_empty;
  assign st.row_ok     = (rdata & mask) == mask;
  assign st.row_last   = row_q == row_last_q;
  assign st.out_full   = out_valid;

  always_comb begin
    ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_MARK);
    ram_waddr = (cmd.op == OP_CLEAR) ? clr_row : row_q;
    priority if (cmd.op == OP_CLEAR) ram_wdata = '1;
    else if (is_free)                ram_wdata = rdata | mask;
    else                             ram_wdata = rdata & ~mask;
  end

  bnfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row_q),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      cell_bytes   <= CELL_BYTES_RESET;
      cells_in_use <= CELLS_IN_USE_RESET;
      next_pos     <= '0;
      clr_row      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_REGION_BASE:  region_base  <= cfg_data;
          CFG_CELL_BYTES:   cell_bytes   <= cfg_data[CB_W-1:0];
          CFG_CELLS_IN_USE: cells_in_use <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (cmd.op == OP_ADDR) begin
        next_pos <= (NUM_W'(hi) == n_eff) ? '0 : POS_W'(hi);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status        <= res_status;
      out_data.alloc_address <= res_addr;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        is_free    <= in_data.command == CMD_FREE;
        cnt        <= in_data.cell_count;
        reject     <= NUM_W'(in_data.cell_count) > n_eff;
        zero_count <= in_data.cell_count == '0;
        lo         <= RUN_W'(start_sel);
        hi         <= RUN_W'(start_sel) + RUN_W'(in_data.cell_count);
        dd         <= in_data.free_address - region_base;
        rem        <= '0;
        div_cnt    <= '0;
        res_status <= STATUS_OK;
        res_addr   <= '0;
      end
      OP_DIV: begin
        rem     <= div_ge ? CB_W'(rem_sh - {1'b0, cb_eff}) : CB_W'(rem_sh);
        dd      <= {dd[ADDR_W-2:0], div_ge};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      OP_FREE_SETUP: begin
        res_status <= clipped ? STATUS_FREE_CLIPPED : STATUS_OK;
        free_empty <= ({1'b0, dd} >= n_wide) || (cnt == '0);
        lo         <= RUN_W'(dd);
        hi         <= clipped ? RUN_W'(n_eff) : RUN_W'(pos_end);
      end
      OP_ROW_START: begin
        row_q      <= ROW_W'(lo >> WB_W);
        row_last_q <= ROW_W'(last_pos >> WB_W);
      end
      OP_CHECK: begin
        if (!st.row_ok) begin
          res_status <= STATUS_ALLOC_FAIL;
        end else if (!st.row_last) begin
          row_q <= row_q + ROW_W'(1);
        end
      end
      OP_MARK: begin
        if (!st.row_last) begin
          row_q <= row_q + ROW_W'(1);
        end
      end
      OP_FAIL: res_status <= STATUS_ALLOC_FAIL;
      OP_MUL:  prod <= PROD_W'(lo) * PROD_W'(cb_eff);
      OP_ADDR: res_addr <= region_base + ADDR_W'(prod);
      default: ;
    endcase
  end

endmodule

/* rtl/core/bitmap_next_fit_allocator.sv */
// Next-fit contiguous cell allocator over a free bitmap.
// Request channel (in_valid/in_ready/in_data): one transaction is an allocate
// or a free of cell_count contiguous cells. Response channel
// (out_valid/out_ready/out_data): exactly one transaction per request, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// region_base, cell_bytes or cells_in_use only while no request is in flight.
// The bitmap lives in a RAM of 32-cell words (8-cell when MAX_CELLS < 32),
// walked one word at a time. Order of work from accept to response:
//   allocate rejected up front: straight to the response; zero length: address only
//   allocate: check pass, then mark pass, then address
//   free: the 48-step bit-serial divider, then a mark pass
// One request is processed at a time; a new request is taken as soon as the
// previous one has moved to the output register, even while that response
// still waits for out_ready. A stalled response holds the block in its final
// step only when a second response is ready behind it.
// After reset the block sweeps the bitmap RAM to all free, one word per cycle;
// in_ready stays low during the sweep.
module bitmap_next_fit_allocator import bnfa_pkg::*; #(
  parameter int MAX_CELLS = DEFAULT_MAX_CELLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alloc_req_t           in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alloc_rsp_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t st;

  bnfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: config registers, divider, bitmap RAM, result register
  bnfa_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
